>>> sv/gptt_pkg.sv
// Shared constants, types and the arctangent table of the pan/tilt tracker.
`default_nettype none
package gptt_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;
   localparam int ATAN_ITER_DEFAULT   = 16;

   // CORDIC datapath: 64-bit words handled one 8-bit digit per cycle
   localparam int CORDIC_W     = 64;
   localparam int CORDIC_SCALE = 56;
   localparam int DIGIT_W      = 8;
   localparam int DIGIT_SH     = $clog2(DIGIT_W);
   localparam int NUM_DIGITS   = CORDIC_W / DIGIT_W;
   localparam int DIGIT_IDX_W  = $clog2(NUM_DIGITS);
   localparam int BIT_IDX_W    = $clog2(CORDIC_W);

   localparam int ATAN_TABLE_DEPTH = 24;
   localparam int ATAN_IDX_W       = 5;
   localparam int ATAN_VAL_W       = 22;
   localparam int ACC_W            = 25;
   localparam int ANGLE_W          = 15;
   localparam int DEG90_Q16        = 90 * 65536;
   localparam int DEG90_Q8         = 90 * 256;

   localparam int DIV_W      = 7;
   localparam int LIMIT_W    = 8;
   localparam int FRAC_W     = 8;
   localparam int POS_W      = LIMIT_W + FRAC_W;
   localparam int POS_EXT_W  = POS_W + 2;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAN_DIV    = 4'd0,
      CSR_TILT_DIV   = 4'd1,
      CSR_PAN_MIN    = 4'd2,
      CSR_PAN_MAX    = 4'd3,
      CSR_TILT_MIN   = 4'd4,
      CSR_TILT_MAX   = 4'd5,
      CSR_PAN_START  = 4'd6,
      CSR_TILT_START = 4'd7
   } csr_index_type;

   localparam logic [DIV_W-1:0]   PAN_DIV_RESET    = 7'd16;
   localparam logic [DIV_W-1:0]   TILT_DIV_RESET   = 7'd8;
   localparam logic [LIMIT_W-1:0] PAN_MIN_RESET    = 8'd65;
   localparam logic [LIMIT_W-1:0] PAN_MAX_RESET    = 8'd87;
   localparam logic [LIMIT_W-1:0] TILT_MIN_RESET   = 8'd56;
   localparam logic [LIMIT_W-1:0] TILT_MAX_RESET   = 8'd79;
   localparam logic [LIMIT_W-1:0] PAN_START_RESET  = 8'd76;
   localparam logic [LIMIT_W-1:0] TILT_START_RESET = 8'd77;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_AXIS,
      SEQ_ANGLE,
      SEQ_STEP,
      SEQ_DIVIDE,
      SEQ_APPLY,
      SEQ_OUTPUT
   } seq_state_type;

   // atan(2^-i) in degrees * 65536, rounded to nearest
   function automatic logic [ATAN_VAL_W-1:0] atan_deg_q16(input logic [ATAN_IDX_W-1:0] idx);
      logic [ATAN_VAL_W-1:0] val;
      case (idx)
         5'd0:    val = 22'd2949120;
         5'd1:    val = 22'd1740967;
         5'd2:    val = 22'd919879;
         5'd3:    val = 22'd466945;
         5'd4:    val = 22'd234379;
         5'd5:    val = 22'd117304;
         5'd6:    val = 22'd58666;
         5'd7:    val = 22'd29335;
         5'd8:    val = 22'd14668;
         5'd9:    val = 22'd7334;
         5'd10:   val = 22'd3667;
         5'd11:   val = 22'd1833;
         5'd12:   val = 22'd917;
         5'd13:   val = 22'd458;
         5'd14:   val = 22'd229;
         5'd15:   val = 22'd115;
         5'd16:   val = 22'd57;
         5'd17:   val = 22'd29;
         5'd18:   val = 22'd14;
         5'd19:   val = 22'd7;
         5'd20:   val = 22'd4;
         5'd21:   val = 22'd2;
         5'd22:   val = 22'd1;
         default: val = 22'd0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

>>> sv/gptt_ifs.sv
// Request, response and register-write channel interfaces of the tracker.
`default_nettype none
interface gptt_req_if #(parameter int OFFSET_BITS = gptt_pkg::OFFSET_BITS_DEFAULT);
   logic                          valid;
   logic                          ready;
   logic signed [OFFSET_BITS-1:0] offset_x;
   logic signed [OFFSET_BITS-1:0] offset_y;
   logic signed [OFFSET_BITS-1:0] offset_z;
   modport source (output valid, offset_x, offset_y, offset_z, input ready);
   modport sink (input valid, offset_x, offset_y, offset_z, output ready);
endinterface

interface gptt_rsp_if;
   import gptt_pkg::*;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] pan_position;
   logic [POS_W-1:0] tilt_position;
   modport source (output valid, pan_position, tilt_position, input ready);
   modport sink (input valid, pan_position, tilt_position, output ready);
endinterface

interface gptt_csr_if;
   import gptt_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/gptt_cordic.sv
// Digit-serial CORDIC vectoring unit: atan(num/den) magnitude in Q7.8 degrees.
`default_nettype none
module gptt_cordic #(
   parameter int OFFSET_BITS     = gptt_pkg::OFFSET_BITS_DEFAULT,
   parameter int ATAN_ITERATIONS = gptt_pkg::ATAN_ITER_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [OFFSET_BITS-1:0]       num_mag,
   input  logic [OFFSET_BITS-1:0]       den_mag,
   output logic                         done,
   output logic [gptt_pkg::ANGLE_W-1:0] angle_mag
);
   import gptt_pkg::*;

   localparam int PRESHIFT  = CORDIC_SCALE - OFFSET_BITS;
   localparam int TOP_PAD   = CORDIC_W - CORDIC_SCALE;
   localparam int ITER_W    = $clog2(ATAN_ITERATIONS);
   localparam int POS_IDX_W = $clog2(CORDIC_W + ATAN_TABLE_DEPTH + DIGIT_W);

   logic [CORDIC_W-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ITER_W-1:0]      iter_ff, iter_in;
   logic [DIGIT_IDX_W-1:0] digit_ff, digit_in;
   logic                   carry_x_ff, carry_x_in, carry_y_ff, carry_y_in;
   logic                   neg_ff, neg_in, run_ff, run_in, done_ff, done_in;

   logic                   neg, cin_x, cin_y;
   logic [BIT_IDX_W-1:0]   base;
   logic [POS_IDX_W-1:0]   tap;
   logic [DIGIT_W-1:0]     sx, sy, cx_dig, cy_dig;
   logic [DIGIT_W:0]       sum_x, sum_y;
   logic signed [ACC_W-1:0] tv;
   logic [ACC_W-1:0]       rounded;

   always_comb begin
      neg    = (digit_ff == '0) ? cy_ff[CORDIC_W-1] : neg_ff;
      cin_x  = (digit_ff == '0) ? neg : carry_x_ff;
      cin_y  = (digit_ff == '0) ? ~neg : carry_y_ff;
      base   = {digit_ff, {DIGIT_SH{1'b0}}};
      tap    = '0;
      // arithmetic right shift by the iteration count, one digit at a time
      for (int b = 0; b < DIGIT_W; b++) begin
         tap = POS_IDX_W'(base) + POS_IDX_W'(b) + POS_IDX_W'(iter_ff);
         if (tap >= POS_IDX_W'(CORDIC_W)) begin
            sx[b] = cx_ff[CORDIC_W-1];
            sy[b] = cy_ff[CORDIC_W-1];
         end else begin
            sx[b] = cx_ff[tap[BIT_IDX_W-1:0]];
            sy[b] = cy_ff[tap[BIT_IDX_W-1:0]];
         end
      end
      cx_dig = cx_ff[base +: DIGIT_W];
      cy_dig = cy_ff[base +: DIGIT_W];
      sum_x  = {1'b0, cx_dig} + {1'b0, (neg ? ~sy : sy)} + {{DIGIT_W{1'b0}}, cin_x};
      sum_y  = {1'b0, cy_dig} + {1'b0, (neg ? sx : ~sx)} + {{DIGIT_W{1'b0}}, cin_y};
      tv     = signed'(ACC_W'(atan_deg_q16(ATAN_IDX_W'(iter_ff))));

      cx_in      = cx_ff;
      cy_in      = cy_ff;
      acc_in     = acc_ff;
      iter_in    = iter_ff;
      digit_in   = digit_ff;
      carry_x_in = carry_x_ff;
      carry_y_in = carry_y_ff;
      neg_in     = neg_ff;
      run_in     = run_ff;
      done_in    = 1'b0;

      if (start) begin
         cx_in    = {{TOP_PAD{1'b0}}, den_mag, {PRESHIFT{1'b0}}};
         cy_in    = {{TOP_PAD{1'b0}}, num_mag, {PRESHIFT{1'b0}}};
         acc_in   = '0;
         iter_in  = '0;
         digit_in = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         cx_in[base +: DIGIT_W] = sum_x[DIGIT_W-1:0];
         cy_in[base +: DIGIT_W] = sum_y[DIGIT_W-1:0];
         carry_x_in = sum_x[DIGIT_W];
         carry_y_in = sum_y[DIGIT_W];
         neg_in     = neg;
         if (digit_ff == DIGIT_IDX_W'(NUM_DIGITS - 1)) begin
            acc_in   = neg ? (acc_ff - tv) : (acc_ff + tv);
            digit_in = '0;
            if (iter_ff == ITER_W'(ATAN_ITERATIONS - 1)) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end else begin
               iter_in = iter_ff + ITER_W'(1);
            end
         end else begin
            digit_in = digit_ff + DIGIT_IDX_W'(1);
         end
      end

      // clamp to 0..90 degrees and round half up to Q7.8
      rounded = ACC_W'(acc_ff) + ACC_W'(128);
      if (acc_ff[ACC_W-1]) begin
         angle_mag = '0;
      end else if (acc_ff > signed'(ACC_W'(DEG90_Q16))) begin
         angle_mag = ANGLE_W'(DEG90_Q8);
      end else begin
         angle_mag = rounded[ANGLE_W+FRAC_W-1:FRAC_W];
      end
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      acc_ff     <= acc_in;
      iter_ff    <= iter_in;
      digit_ff   <= digit_in;
      carry_x_ff <= carry_x_in;
      carry_y_ff <= carry_y_in;
      neg_ff     <= neg_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/gptt_divider.sv
// Bit-serial restoring divider for the position step: angle / divisor.
`default_nettype none
module gptt_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [gptt_pkg::ANGLE_W-1:0] dividend,
   input  logic [gptt_pkg::DIV_W-1:0]   divisor,
   output logic                         done,
   output logic [gptt_pkg::ANGLE_W-1:0] quotient
);
   import gptt_pkg::*;

   localparam int CNT_W = $clog2(ANGLE_W);

   logic [ANGLE_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0]   rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in, done_ff, done_in;
   logic [DIV_W:0]     trial, diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[ANGLE_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // shift in one dividend bit, keep the remainder below the divisor
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[ANGLE_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[ANGLE_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(ANGLE_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/gimbal_pan_tilt_tracker_unit.sv
// Top level of the pan/tilt tracker: sequencer, registers and axis update.
//
// Usage: one request on req_bus carries a target offset (x, y, z), signed
// fixed point with 16 fraction bits. Each request yields exactly one
// response on rsp_bus with the pan and tilt positions in Q8.8.
// Registers are written on csr_bus (always ready); the user must write
// them only while no request is in flight, as the block does not enforce
// it; writing a start register also loads that axis position.
// Per request, pan is handled first, then tilt. An axis whose input
// equals the last value acted on is skipped. Otherwise the angle is zero
// for a zero axis offset, a full quarter turn for a zero z offset, and
// else comes from the digit-serial CORDIC over ATAN_ITERATIONS
// iterations; then a bit-serial divide runs when the angle leaves the
// dead band, and the step is applied and clamped.
// One request is in work at a time; the next is accepted once the
// sequencer is back in idle.
// The response sits in an output register: a stalled receiver does not
// block acceptance of the next request, only its completion.
// Reset (synchronous) restores register defaults, loads both positions
// from the start values and clears the last-seen offsets to zero.
`default_nettype none
module gimbal_pan_tilt_tracker_unit #(
   parameter int OFFSET_BITS     = gptt_pkg::OFFSET_BITS_DEFAULT,
   parameter int ATAN_ITERATIONS = gptt_pkg::ATAN_ITER_DEFAULT
) (
   input logic clock,
   input logic reset,
   gptt_req_if.sink   req_bus,
   gptt_rsp_if.source rsp_bus,
   gptt_csr_if.sink   csr_bus
);
   import gptt_pkg::*;

   seq_state_type state_ff, state_in;

   // configuration
   logic [DIV_W-1:0]   pan_div_ff, pan_div_in, tilt_div_ff, tilt_div_in;
   logic [LIMIT_W-1:0] pan_min_ff, pan_min_in, pan_max_ff, pan_max_in;
   logic [LIMIT_W-1:0] tilt_min_ff, tilt_min_in, tilt_max_ff, tilt_max_in;
   logic [LIMIT_W-1:0] pan_start_ff, pan_start_in, tilt_start_ff, tilt_start_in;

   // axis state
   logic [POS_W-1:0]       pan_pos_ff, pan_pos_in, tilt_pos_ff, tilt_pos_in;
   logic [OFFSET_BITS-1:0] last_x_ff, last_x_in, last_y_ff, last_y_in;

   // request capture and working registers
   logic [OFFSET_BITS-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                   axis_ff, axis_in, sign_ff, sign_in;
   logic [ANGLE_W-1:0]     ang_ff, ang_in, step_ff, step_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] rsp_pan_ff, rsp_pan_in, rsp_tilt_ff, rsp_tilt_in;

   // datapath helpers
   logic [OFFSET_BITS-1:0] n_sel, last_sel, n_mag, z_mag;
   logic                   n_neg, z_neg, cordic_start, cordic_done;
   logic [ANGLE_W-1:0]     cordic_angle, div_quot;
   logic                   div_start, div_done;
   logic [DIV_W-1:0]       div_raw, div_eff;
   logic [ANGLE_W-1:0]     band;
   logic [POS_W-1:0]       pos_cur, pos_new;
   logic [LIMIT_W-1:0]     lim_hi, lim_lo;
   logic signed [POS_EXT_W-1:0] pos_ext, step_ext, pos_sum, hi_ext, lo_ext;
   logic                   accept_req, rsp_free;

   gptt_cordic #(
      .OFFSET_BITS    (OFFSET_BITS),
      .ATAN_ITERATIONS(ATAN_ITERATIONS)
   ) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .start    (cordic_start),
      .num_mag  (n_mag),
      .den_mag  (z_mag),
      .done     (cordic_done),
      .angle_mag(cordic_angle)
   );

   gptt_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(ang_ff),
      .divisor (div_eff),
      .done    (div_done),
      .quotient(div_quot)
   );

   assign req_bus.ready         = (state_ff == SEQ_IDLE);
   assign accept_req            = req_bus.valid && (state_ff == SEQ_IDLE);
   assign rsp_free              = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.pan_position  = rsp_pan_ff;
   assign rsp_bus.tilt_position = rsp_tilt_ff;
   assign csr_bus.ready         = 1'b1;

   always_comb begin
      // select the axis being worked on
      n_sel    = axis_ff ? y_ff : x_ff;
      last_sel = axis_ff ? last_y_ff : last_x_ff;
      n_neg    = n_sel[OFFSET_BITS-1];
      z_neg    = z_ff[OFFSET_BITS-1];
      n_mag    = n_neg ? ((~n_sel) + OFFSET_BITS'(1)) : n_sel;
      z_mag    = z_neg ? ((~z_ff) + OFFSET_BITS'(1)) : z_ff;

      // a zero divisor counts as one; dead band is (divisor - 1) degrees
      div_raw  = axis_ff ? tilt_div_ff : pan_div_ff;
      div_eff  = (div_raw == '0) ? DIV_W'(1) : div_raw;
      band     = {div_eff - DIV_W'(1), {FRAC_W{1'b0}}};

      // add or subtract the step, then clamp: the upper limit wins
      pos_cur  = axis_ff ? tilt_pos_ff : pan_pos_ff;
      lim_hi   = axis_ff ? tilt_max_ff : pan_max_ff;
      lim_lo   = axis_ff ? tilt_min_ff : pan_min_ff;
      pos_ext  = signed'({2'b00, pos_cur});
      step_ext = signed'(POS_EXT_W'(step_ff));
      hi_ext   = signed'({2'b00, lim_hi, {FRAC_W{1'b0}}});
      lo_ext   = signed'({2'b00, lim_lo, {FRAC_W{1'b0}}});
      pos_sum  = (sign_ff != axis_ff) ? (pos_ext - step_ext) : (pos_ext + step_ext);
      if (pos_sum > hi_ext) begin
         pos_new = POS_W'(hi_ext);
      end else if (pos_sum < lo_ext) begin
         pos_new = POS_W'(lo_ext);
      end else begin
         pos_new = POS_W'(pos_sum);
      end

      state_in      = state_ff;
      pan_div_in    = pan_div_ff;
      tilt_div_in   = tilt_div_ff;
      pan_min_in    = pan_min_ff;
      pan_max_in    = pan_max_ff;
      tilt_min_in   = tilt_min_ff;
      tilt_max_in   = tilt_max_ff;
      pan_start_in  = pan_start_ff;
      tilt_start_in = tilt_start_ff;
      pan_pos_in    = pan_pos_ff;
      tilt_pos_in   = tilt_pos_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      axis_in       = axis_ff;
      sign_in       = sign_ff;
      ang_in        = ang_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_pan_in    = rsp_pan_ff;
      rsp_tilt_in   = rsp_tilt_ff;
      cordic_start  = 1'b0;
      div_start     = 1'b0;

      unique case (state_ff)
         SEQ_IDLE: begin
            // capture the request, start with the pan axis
            if (accept_req) begin
               x_in     = req_bus.offset_x;
               y_in     = req_bus.offset_y;
               z_in     = req_bus.offset_z;
               axis_in  = 1'b0;
               state_in = SEQ_AXIS;
            end
         end
         SEQ_AXIS: begin
            if (n_sel == last_sel) begin
               // unchanged input: leave the axis alone, no clamp
               if (axis_ff) begin
                  state_in = SEQ_OUTPUT;
               end else begin
                  axis_in = 1'b1;
               end
            end else begin
               sign_in = n_neg ^ z_neg;
               if (axis_ff) begin
                  last_y_in = n_sel;
               end else begin
                  last_x_in = n_sel;
               end
               if (n_mag == '0) begin
                  ang_in   = '0;
                  state_in = SEQ_STEP;
               end else if (z_mag == '0) begin
                  // target straight to the side: a full quarter turn
                  ang_in   = ANGLE_W'(DEG90_Q8);
                  state_in = SEQ_STEP;
               end else begin
                  cordic_start = 1'b1;
                  state_in     = SEQ_ANGLE;
               end
            end
         end
         SEQ_ANGLE: begin
            if (cordic_done) begin
               ang_in   = cordic_angle;
               state_in = SEQ_STEP;
            end
         end
         SEQ_STEP: begin
            if (ang_ff > band) begin
               div_start = 1'b1;
               state_in  = SEQ_DIVIDE;
            end else begin
               step_in  = '0;
               state_in = SEQ_APPLY;
            end
         end
         SEQ_DIVIDE: begin
            if (div_done) begin
               step_in  = div_quot;
               state_in = SEQ_APPLY;
            end
         end
         SEQ_APPLY: begin
            if (axis_ff) begin
               tilt_pos_in = pos_new;
               state_in    = SEQ_OUTPUT;
            end else begin
               pan_pos_in = pos_new;
               axis_in    = 1'b1;
               state_in   = SEQ_AXIS;
            end
         end
         SEQ_OUTPUT: begin
            // hold until the response register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pan_in   = pan_pos_ff;
               rsp_tilt_in  = tilt_pos_ff;
               state_in     = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase

      // register writes; a start value also reloads its position
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_PAN_DIV:    pan_div_in  = csr_bus.data[DIV_W-1:0];
            CSR_TILT_DIV:   tilt_div_in = csr_bus.data[DIV_W-1:0];
            CSR_PAN_MIN:    pan_min_in  = csr_bus.data[LIMIT_W-1:0];
            CSR_PAN_MAX:    pan_max_in  = csr_bus.data[LIMIT_W-1:0];
            CSR_TILT_MIN:   tilt_min_in = csr_bus.data[LIMIT_W-1:0];
            CSR_TILT_MAX:   tilt_max_in = csr_bus.data[LIMIT_W-1:0];
            CSR_PAN_START: begin
               pan_start_in = csr_bus.data[LIMIT_W-1:0];
               pan_pos_in   = {csr_bus.data[LIMIT_W-1:0], {FRAC_W{1'b0}}};
            end
            CSR_TILT_START: begin
               tilt_start_in = csr_bus.data[LIMIT_W-1:0];
               tilt_pos_in   = {csr_bus.data[LIMIT_W-1:0], {FRAC_W{1'b0}}};
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      axis_ff     <= axis_in;
      sign_ff     <= sign_in;
      ang_ff      <= ang_in;
      step_ff     <= step_in;
      rsp_pan_ff  <= rsp_pan_in;
      rsp_tilt_ff <= rsp_tilt_in;
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         pan_div_ff    <= PAN_DIV_RESET;
         tilt_div_ff   <= TILT_DIV_RESET;
         pan_min_ff    <= PAN_MIN_RESET;
         pan_max_ff    <= PAN_MAX_RESET;
         tilt_min_ff   <= TILT_MIN_RESET;
         tilt_max_ff   <= TILT_MAX_RESET;
         pan_start_ff  <= PAN_START_RESET;
         tilt_start_ff <= TILT_START_RESET;
         pan_pos_ff    <= {PAN_START_RESET, {FRAC_W{1'b0}}};
         tilt_pos_ff   <= {TILT_START_RESET, {FRAC_W{1'b0}}};
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pan_div_ff    <= pan_div_in;
         tilt_div_ff   <= tilt_div_in;
         pan_min_ff    <= pan_min_in;
         pan_max_ff    <= pan_max_in;
         tilt_min_ff   <= tilt_min_in;
         tilt_max_ff   <= tilt_max_in;
         pan_start_ff  <= pan_start_in;
         tilt_start_ff <= tilt_start_in;
         pan_pos_ff    <= pan_pos_in;
         tilt_pos_ff   <= tilt_pos_in;
         last_x_ff     <= last_x_in;
         last_y_ff     <= last_y_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire
